>>> rtl/core/eae_pkg.sv
`timescale 1ns / 1ps

package eae_pkg;

	// note on during a running envelope goes through a forced release first
	localparam logic FORCED_RELEASE_ON = 1'b1;

	localparam int CNT_W = 20;
	localparam int LEN_W = 16;
	localparam int COEF_W = 31;
	localparam int LVL_W = 32;
	localparam int MUL_B_W = LVL_W + 1;
	localparam int PROD_W = (COEF_W + 1) + MUL_B_W;
	localparam int SUM_W = PROD_W - 30;
	localparam int OUT_LVL_W = LVL_W - 14;

	localparam logic [LVL_W-1:0] UNITY = 32'h4000_0000;
	localparam logic signed [MUL_B_W-1:0] RELEASE_TGT = -33'sd256;
	localparam logic signed [MUL_B_W-1:0] FORCED_TGT = -33'sd16777216;

	// register reset values
	localparam logic [LEN_W-1:0] DELAY_LENGTH_RST = 16'd0;
	localparam logic [LEN_W-1:0] HOLD_LENGTH_RST = 16'd0;
	localparam logic [COEF_W-1:0] SUSTAIN_LEVEL_RST = 31'd536870912;
	localparam logic [COEF_W-1:0] ATTACK_COEF_RST = 31'd1063004405;
	localparam logic [COEF_W-1:0] ATTACK_STEP_RST = 31'd16777216;
	localparam logic [COEF_W-1:0] DECAY_COEF_RST = 31'd1063004405;
	localparam logic [COEF_W-1:0] RELEASE_COEF_RST = 31'd1063004405;
	localparam logic [COEF_W-1:0] FORCED_COEF_RST = 31'd1000000000;

	typedef enum logic [2:0] {
		REG_DELAY_LENGTH  = 3'd0,
		REG_HOLD_LENGTH   = 3'd1,
		REG_SUSTAIN_LEVEL = 3'd2,
		REG_ATTACK_COEF   = 3'd3,
		REG_ATTACK_STEP   = 3'd4,
		REG_DECAY_COEF    = 3'd5,
		REG_RELEASE_COEF  = 3'd6,
		REG_FORCED_COEF   = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_SAMPLE   = 2'd0,
		CMD_NOTE_ON  = 2'd1,
		CMD_NOTE_OFF = 2'd2,
		CMD_UNUSED   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		OP_SAMPLE,
		OP_NOTE_ON,
		OP_NOTE_OFF,
		OP_NONE
	} op_t;

	typedef enum logic [7:0] {
		PH_IDLE    = 8'b0000_0001,
		PH_DELAY   = 8'b0000_0010,
		PH_ATTACK  = 8'b0000_0100,
		PH_HOLD    = 8'b0000_1000,
		PH_DECAY   = 8'b0001_0000,
		PH_SUSTAIN = 8'b0010_0000,
		PH_RELEASE = 8'b0100_0000,
		PH_FORCED  = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		op_t                op;
		logic signed [15:0] sample;
	} item_t;

	typedef struct packed {
		logic [LEN_W-1:0]  delay_length;
		logic [LEN_W-1:0]  hold_length;
		logic [COEF_W-1:0] sustain_level;
		logic [COEF_W-1:0] attack_coef;
		logic [COEF_W-1:0] attack_step;
		logic [COEF_W-1:0] decay_coef;
		logic [COEF_W-1:0] release_coef;
		logic [COEF_W-1:0] forced_coef;
	} cfg_t;

	// one beat handed from the envelope stage to the output stage
	typedef struct packed {
		logic signed [OUT_LVL_W-1:0] lvl;
		logic signed [15:0]          sample;
		logic                        active;
		logic                        sustaining;
	} res_t;

endpackage

>>> rtl/core/eae_front.sv
`timescale 1ns / 1ps

module eae_front import eae_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [15:0] sample_in,
	output logic        q_valid,
	output item_t       q_item,
	input  logic        q_pop
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	item_t      cls;
	logic       push;

	// decode the command into an operation
	always_comb begin
		cls.sample = sample_in;
		unique case (cmd)
			CMD_SAMPLE:   cls.op = OP_SAMPLE;
			CMD_NOTE_ON:  cls.op = OP_NOTE_ON;
			CMD_NOTE_OFF: cls.op = OP_NOTE_OFF;
			default:      cls.op = OP_NONE;
		endcase
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rd_ptr_q];

	// store the beat
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			priority if (push && !q_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (q_pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

>>> rtl/core/eae_back.sv
`timescale 1ns / 1ps

module eae_back import eae_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  q_valid,
	input  item_t q_item,
	output logic  q_pop,
	input  logic  s2_ready,
	output logic  vld_s1,
	output res_t  res_s1
);

	phase_t                    phase_q;
	logic [LVL_W-1:0]          level_q;
	logic [CNT_W-1:0]          cnt_q;

	phase_t                    nphase;
	logic [LVL_W-1:0]          nlevel;
	logic [CNT_W-1:0]          ncnt;
	logic [CNT_W-1:0]          dly8;
	logic [CNT_W-1:0]          hold8;
	logic [COEF_W-1:0]         coef;
	logic signed [MUL_B_W-1:0] tgt;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [SUM_W-1:0]   appr;
	logic [SUM_W-1:0]          att_sum;
	logic [LVL_W-1:0]          appr_lvl;
	logic                      lvl_low_zero;
	logic                      s1_ready;
	res_t                      nres;

	assign s1_ready = !vld_s1 || s2_ready;
	assign q_pop    = q_valid && s1_ready;

	assign dly8  = {1'b0, cfg.delay_length, 3'b000};
	assign hold8 = {1'b0, cfg.hold_length, 3'b000};

	// pick coefficient and target for the current phase
	always_comb begin
		unique case (phase_q)
			PH_ATTACK: begin
				coef = cfg.attack_coef;
				tgt  = '0;
			end
			PH_RELEASE: begin
				coef = cfg.release_coef;
				tgt  = RELEASE_TGT;
			end
			PH_FORCED: begin
				coef = cfg.forced_coef;
				tgt  = FORCED_TGT;
			end
			default: begin
				coef = cfg.decay_coef;
				tgt  = {2'b00, cfg.sustain_level};
			end
		endcase
		if (phase_q == PH_ATTACK) begin
			mul_b = {1'b0, level_q};
		end else begin
			mul_b = $signed({level_q[LVL_W-1], level_q}) - tgt;
		end
	end

	// one multiply-add per sample
	assign prod     = $signed({1'b0, coef}) * mul_b;
	assign appr     = prod[PROD_W-1:30] + {{(SUM_W-MUL_B_W){tgt[MUL_B_W-1]}}, tgt};
	assign att_sum  = prod[PROD_W-1:30] + {{(SUM_W-COEF_W){1'b0}}, cfg.attack_step};
	assign appr_lvl = appr[LVL_W-1:0];
	// filtered level is zero or negative after dropping the fraction bits
	assign lvl_low_zero = appr_lvl[LVL_W-1] || (appr_lvl[LVL_W-1:14] == '0);

	// next envelope state for the beat at the head of the queue
	always_comb begin
		nphase = phase_q;
		nlevel = level_q;
		ncnt   = cnt_q;
		unique case (q_item.op)
			OP_NOTE_ON: begin
				if (!FORCED_RELEASE_ON || phase_q == PH_IDLE) begin
					nlevel = '0;
					ncnt   = dly8;
					nphase = (cfg.delay_length != '0) ? PH_DELAY : PH_ATTACK;
				end else begin
					nphase = PH_FORCED;
				end
			end
			OP_NOTE_OFF: begin
				if (phase_q == PH_IDLE || phase_q == PH_DELAY) begin
					nphase = PH_IDLE;
				end else begin
					nphase = PH_RELEASE;
				end
			end
			OP_SAMPLE: begin
				unique case (phase_q)
					PH_DELAY: begin
						if (cnt_q != '0) begin
							ncnt = cnt_q - 1'b1;
						end else begin
							nphase = PH_ATTACK;
						end
					end
					PH_ATTACK: begin
						if (att_sum[SUM_W-1:30] != '0) begin
							nlevel = UNITY;
							if (cfg.hold_length != '0) begin
								ncnt   = hold8;
								nphase = PH_HOLD;
							end else begin
								ncnt   = dly8;
								nphase = PH_DECAY;
							end
						end else begin
							nlevel = att_sum[LVL_W-1:0];
						end
					end
					PH_HOLD: begin
						if (cnt_q == '0) begin
							nphase = PH_DECAY;
							ncnt   = dly8;
						end else begin
							ncnt = cnt_q - 1'b1;
						end
					end
					PH_DECAY: begin
						if (cnt_q == '0) begin
							nphase = PH_SUSTAIN;
						end else begin
							ncnt = cnt_q - 1'b1;
						end
						nlevel = appr_lvl;
					end
					PH_SUSTAIN: begin
						nlevel = appr_lvl;
					end
					PH_RELEASE: begin
						nlevel = appr_lvl[LVL_W-1] ? '0 : appr_lvl;
						if (lvl_low_zero) begin
							nphase = PH_IDLE;
						end
					end
					PH_FORCED: begin
						if (lvl_low_zero) begin
							nlevel = '0;
							nphase = PH_ATTACK;
						end else begin
							nlevel = appr_lvl;
						end
					end
					default: begin
						nphase = PH_IDLE;
					end
				endcase
			end
			default: begin
				nphase = phase_q;
			end
		endcase

		nres.lvl        = nlevel[LVL_W-1:14];
		nres.sample     = (q_item.op == OP_SAMPLE && phase_q != PH_IDLE && nphase != PH_IDLE)
			? q_item.sample : '0;
		nres.active     = (nphase != PH_IDLE);
		nres.sustaining = (nphase == PH_SUSTAIN);
	end

	// update envelope state on each popped beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			level_q <= '0;
			cnt_q   <= '0;
		end else if (q_pop) begin
			phase_q <= nphase;
			level_q <= nlevel;
			cnt_q   <= ncnt;
		end
	end

	// hand the result to the output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s1_ready) begin
			vld_s1 <= q_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_s1 <= nres;
		end
	end

endmodule

>>> rtl/core/eae_out.sv
`timescale 1ns / 1ps

module eae_out import eae_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        vld_s1,
	input  res_t        res_s1,
	output logic        s2_ready,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] sample_out,
	output logic        active,
	output logic        sustaining
);

	localparam int P_W = OUT_LVL_W + 16;

	logic signed [P_W-1:0] prod;
	logic                  vld_s2;
	logic [15:0]           sample_s2;
	logic                  active_s2;
	logic                  sust_s2;

	assign s2_ready = !vld_s2 || !out_stall;

	// scale the sample by the level, keep bits 31:16
	assign prod = res_s1.lvl * res_s1.sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_ready) begin
			vld_s2 <= vld_s1;
		end
	end

	// hold the output beat while stalled
	always_ff @(posedge clk) begin
		if (s2_ready && vld_s1) begin
			sample_s2 <= prod[31:16];
			active_s2 <= res_s1.active;
			sust_s2   <= res_s1.sustaining;
		end
	end

	assign out_valid  = vld_s2;
	assign sample_out = sample_s2;
	assign active     = active_s2;
	assign sustaining = sust_s2;

endmodule

>>> rtl/core/exponential_adsr_envelope_unit.sv
// channel | direction | beat moves on                 | payload
// in      | input     | in_valid & !in_stall          | cmd, sample_in
// out     | output    | out_valid & !out_stall        | sample_out, active, sustaining
// cfg     | input     | cfg_wr_en                     | cfg_index, cfg_wdata
//
// One beat per cycle sustained while out_stall is low; a taken beat goes through the
// queue write, envelope multiply-add and output scaling registers to out_valid.
// The envelope level loop closes combinationally through one 32x33 multiplier.
// A two-entry queue sits between command decode and the envelope stage, so
// in_stall rises only when that queue is full.
// Reset clears phase, level, counter, queue and output valid; no clearing pass.
`timescale 1ns / 1ps

module exponential_adsr_envelope_unit import eae_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [15:0] sample_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] sample_out,
	output logic        active,
	output logic        sustaining,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [30:0] cfg_wdata
);

	cfg_t  cfg_q;
	logic  q_valid;
	item_t q_item;
	logic  q_pop;
	logic  s2_ready;
	logic  vld_s1;
	res_t  res_s1;

	// register file writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_length  <= DELAY_LENGTH_RST;
			cfg_q.hold_length   <= HOLD_LENGTH_RST;
			cfg_q.sustain_level <= SUSTAIN_LEVEL_RST;
			cfg_q.attack_coef   <= ATTACK_COEF_RST;
			cfg_q.attack_step   <= ATTACK_STEP_RST;
			cfg_q.decay_coef    <= DECAY_COEF_RST;
			cfg_q.release_coef  <= RELEASE_COEF_RST;
			cfg_q.forced_coef   <= FORCED_COEF_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DELAY_LENGTH:  cfg_q.delay_length  <= cfg_wdata[LEN_W-1:0];
				REG_HOLD_LENGTH:   cfg_q.hold_length   <= cfg_wdata[LEN_W-1:0];
				REG_SUSTAIN_LEVEL: cfg_q.sustain_level <= cfg_wdata;
				REG_ATTACK_COEF:   cfg_q.attack_coef   <= cfg_wdata;
				REG_ATTACK_STEP:   cfg_q.attack_step   <= cfg_wdata;
				REG_DECAY_COEF:    cfg_q.decay_coef    <= cfg_wdata;
				REG_RELEASE_COEF:  cfg_q.release_coef  <= cfg_wdata;
				REG_FORCED_COEF:   cfg_q.forced_coef   <= cfg_wdata;
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	eae_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.sample_in (sample_in),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	eae_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.s2_ready (s2_ready),
		.vld_s1   (vld_s1),
		.res_s1   (res_s1)
	);

	eae_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.vld_s1     (vld_s1),
		.res_s1     (res_s1),
		.s2_ready   (s2_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.active     (active),
		.sustaining (sustaining)
	);

	// sustain is a running phase
	a_sust_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sustaining |-> active)
		else $error("sustaining without active");

	// an idle envelope passes no audio
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !active |-> sample_out == 16'd0)
		else $error("nonzero sample while idle");

	// the queue only fills on a pushed beat
	a_stall_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid))
		else $error("input stall rose without a pushed beat");

endmodule
